[hdl/rv32cd_pkg.sv]
// Shared types, opcodes and control codes for the RV32IM control decoder.
package rv32cd_pkg;

  // Major opcodes, bits 6:0
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;

  // funct7 values
  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  // funct3 values that the decoder tests by name
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_LD_BAD_LO = 3'd3;
  localparam logic [2:0] F3_LD_BAD_HI = 3'd7;
  localparam logic [2:0] F3_ST_MAX    = 3'd2;

  // Private ALU codes
  localparam logic [4:0] ALU_ADD   = 5'd0;
  localparam logic [4:0] ALU_SUB   = 5'd1;
  localparam logic [4:0] ALU_SLT   = 5'd3;
  localparam logic [4:0] ALU_XOR   = 5'd4;
  localparam logic [4:0] ALU_SRA   = 5'd6;
  localparam logic [4:0] ALU_OR    = 5'd7;
  localparam logic [4:0] ALU_AND   = 5'd8;
  localparam logic [4:0] ALU_SLLI  = 5'd9;
  localparam logic [4:0] ALU_SRLI  = 5'd10;
  localparam logic [4:0] ALU_SLTIU = 5'd11;
  localparam logic [4:0] ALU_SRAI  = 5'd12;
  localparam logic [4:0] ALU_LOAD  = 5'd15;
  localparam logic [4:0] ALU_BEQ   = 5'd21;
  localparam logic [4:0] ALU_BNE   = 5'd22;
  localparam logic [4:0] ALU_BLT   = 5'd23;
  localparam logic [4:0] ALU_BGE   = 5'd24;
  localparam logic [4:0] ALU_BLTU  = 5'd25;
  localparam logic [4:0] ALU_BGEU  = 5'd26;
  localparam logic [4:0] ALU_STORE = 5'd27;

  // R-type ALU codes by funct3, base and M-extension rows
  localparam logic [4:0] ALU_REG_BASE [8] = '{5'd0, 5'd2, 5'd3, 5'd3,
                                              5'd4, 5'd5, 5'd7, 5'd8};
  localparam logic [4:0] ALU_REG_MUL  [8] = '{5'd16, 5'd17, 5'd18, 5'd19,
                                              5'd20, 5'd28, 5'd29, 5'd30};

  // Branch condition codes
  localparam logic [2:0] BC_EQ  = 3'd0;
  localparam logic [2:0] BC_NE  = 3'd1;
  localparam logic [2:0] BC_LT  = 3'd2;
  localparam logic [2:0] BC_GE  = 3'd3;
  localparam logic [2:0] BC_LTU = 3'd4;
  localparam logic [2:0] BC_GEU = 3'd5;

  // Write-back source select
  localparam logic [1:0] WSEL_ALU  = 2'd0;
  localparam logic [1:0] WSEL_MEM  = 2'd1;
  localparam logic [1:0] WSEL_UIMM = 2'd2;
  localparam logic [1:0] WSEL_LINK = 2'd3;

  // Control strobe bit positions
  localparam int CB_WE   = 0;
  localparam int CB_SRC  = 1;
  localparam int CB_SIGN = 2;
  localparam int CB_DSEL = 3;
  localparam int CB_MRD  = 4;
  localparam int CB_MWR  = 5;
  localparam int CB_JUMP = 6;
  localparam int CB_AUI  = 7;
  localparam int CB_JALR = 8;

  typedef struct packed {
    logic        valid_res;
    logic [4:0]  read_reg_a;
    logic [4:0]  read_reg_b;
    logic [4:0]  write_reg;
    logic [1:0]  write_select;
    logic [11:0] imm_low;
    logic [19:0] imm_upper;
    logic [4:0]  alu_code;
    logic [2:0]  branch_condition;
    logic [12:0] branch_offset;
    logic [1:0]  mem_size;
    logic [8:0]  control_bits;
  } decode_t;

endpackage

[hdl/rv32im_control_decoder_top.sv]
// Top level of the RV32IM control decoder: input register, decode, result register.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  instr in  | instr_valid / instr_stall  | instruction
//  result out| result_valid / result_stall| valid_res .. control_bits
//
//  Throughput: one instruction per cycle, sustained, when result_stall is low.
//  Path: an accepted instruction is captured in the input register, then the
//  decode logic loads it into the result register, where result_valid rises.
//  Reset: rst is synchronous, active high; it empties both stages.
//  Stalls: result_stall holds the result register; the input register still
//  takes a new word while it is empty, so instr_stall rises only when both
//  stages are full and the result side stalls.
module rv32im_control_decoder_top
  import rv32cd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // instruction channel
  input  logic        instr_valid,
  output logic        instr_stall,
  input  logic [31:0] instruction,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        valid_res,
  output logic [4:0]  read_reg_a,
  output logic [4:0]  read_reg_b,
  output logic [4:0]  write_reg,
  output logic [1:0]  write_select,
  output logic [11:0] imm_low,
  output logic [19:0] imm_upper,
  output logic [4:0]  alu_code,
  output logic [2:0]  branch_condition,
  output logic [12:0] branch_offset,
  output logic [1:0]  mem_size,
  output logic [8:0]  control_bits
);

  // Stage 1: captured instruction word
  logic        instr_full;
  logic [31:0] instr_q;

  // Stage 2: registered decode result
  decode_t     dec;
  decode_t     res_q;

  logic        res_ready;   // result register can load this cycle
  logic        instr_ready; // input register can load this cycle
  logic        instr_xfer;
  logic        move;        // stage 1 hands its word to stage 2

  assign res_ready   = !result_valid || !result_stall;
  assign instr_ready = !instr_full || res_ready;
  assign instr_stall = !instr_ready;
  assign instr_xfer  = instr_valid && instr_ready;
  assign move        = instr_full && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      instr_full <= 1'b0;
    end else if (instr_ready) begin
      instr_full <= instr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr_xfer) begin
      instr_q <= instruction;
    end
  end

  rv32cd_decode u_decode (
    .instruction (instr_q),
    .dec         (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= instr_full;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_q <= dec;
    end
  end

  assign valid_res        = res_q.valid_res;
  assign read_reg_a       = res_q.read_reg_a;
  assign read_reg_b       = res_q.read_reg_b;
  assign write_reg        = res_q.write_reg;
  assign write_select     = res_q.write_select;
  assign imm_low          = res_q.imm_low;
  assign imm_upper        = res_q.imm_upper;
  assign alu_code         = res_q.alu_code;
  assign branch_condition = res_q.branch_condition;
  assign branch_offset    = res_q.branch_offset;
  assign mem_size         = res_q.mem_size;
  assign control_bits     = res_q.control_bits;

  // An unsupported instruction leaves every other field at zero.
  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !valid_res) |->
      (read_reg_a == '0 && read_reg_b == '0 && write_reg == '0 &&
       imm_low == '0 && imm_upper == '0 && alu_code == '0 &&
       control_bits == '0 && mem_size == '0 && branch_offset == '0))
    else $error("invalid decode carries nonzero fields");

  // JALR is a jump; load and store strobes never coexist.
  a_strobes : assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      ((!control_bits[CB_JALR] || control_bits[CB_JUMP]) &&
       !(control_bits[CB_MRD] && control_bits[CB_MWR])))
    else $error("inconsistent control strobes");

  // A word waiting in stage 1 with room downstream shows up next cycle.
  a_advance : assert property (@(posedge clk) disable iff (rst)
    move |=> result_valid)
    else $error("stage 1 word lost on advance");

  // Upstream is stalled only when both stages are occupied.
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    instr_stall |-> (instr_full && result_valid))
    else $error("stall raised with an empty stage");

endmodule

[hdl/rv32cd_decode.sv]
// Combinational field decode of one RV32IM instruction word.
module rv32cd_decode
  import rv32cd_pkg::*;
(
  input  logic [31:0] instruction,
  output decode_t     dec
);

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd;
  logic [4:0] rs1;
  logic [4:0] rs2;
  logic       ok;
  decode_t    d;

  assign op  = instruction[6:0];
  assign f3  = instruction[14:12];
  assign f7  = instruction[31:25];
  assign rd  = instruction[11:7];
  assign rs1 = instruction[19:15];
  assign rs2 = instruction[24:20];

  always_comb begin
    d  = '0;
    ok = 1'b0;
    case (op)
      OP_REG: begin
        // operands swapped onto the read ports, as the datapath expects
        d.read_reg_a = rs2;
        d.read_reg_b = rs1;
        d.write_reg  = rd;
        d.control_bits[CB_WE]   = 1'b1;
        d.control_bits[CB_SIGN] = 1'b1;
        if (f7 == F7_BASE) begin
          ok = 1'b1;
          d.alu_code = ALU_REG_BASE[f3];
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) begin
            ok = 1'b1;
            d.alu_code = ALU_SUB;
          end else if (f3 == F3_SR) begin
            ok = 1'b1;
            d.alu_code = ALU_SRA;
          end
        end else if (f7 == F7_MULDIV) begin
          ok = 1'b1;
          d.alu_code = ALU_REG_MUL[f3];
        end
      end
      OP_IMM: begin
        d.imm_low    = instruction[31:20];
        d.read_reg_a = rs1;
        d.write_reg  = rd;
        d.control_bits[CB_WE]   = 1'b1;
        d.control_bits[CB_SRC]  = 1'b1;
        d.control_bits[CB_SIGN] = 1'b1;
        case (f3)
          F3_ADD: begin
            ok = 1'b1;
            d.alu_code = ALU_ADD;
          end
          F3_SLT: begin
            ok = 1'b1;
            d.alu_code = ALU_SLT;
          end
          F3_SLTU: begin
            ok = 1'b1;
            d.alu_code = ALU_SLTIU;
            d.control_bits[CB_SIGN] = 1'b0;
          end
          F3_XOR: begin
            ok = 1'b1;
            d.alu_code = ALU_XOR;
          end
          F3_OR: begin
            ok = 1'b1;
            d.alu_code = ALU_OR;
          end
          F3_AND: begin
            ok = 1'b1;
            d.alu_code = ALU_AND;
          end
          F3_SLL: begin
            if (f7 == F7_BASE) begin
              ok = 1'b1;
              d.alu_code = ALU_SLLI;
            end
          end
          default: begin
            // shift right: logical or arithmetic by funct7
            if (f7 == F7_BASE) begin
              ok = 1'b1;
              d.alu_code = ALU_SRLI;
            end else if (f7 == F7_ALT) begin
              ok = 1'b1;
              d.alu_code = ALU_SRAI;
            end
          end
        endcase
      end
      OP_LOAD: begin
        d.imm_low      = instruction[31:20];
        d.read_reg_a   = rs1;
        d.write_reg    = rd;
        d.write_select = WSEL_MEM;
        d.alu_code     = ALU_LOAD;
        d.control_bits[CB_WE]   = 1'b1;
        d.control_bits[CB_SRC]  = 1'b1;
        d.control_bits[CB_DSEL] = 1'b1;
        d.control_bits[CB_MRD]  = 1'b1;
        if (!(f3 inside {F3_LD_BAD_LO, F3_LD_BAD_HI})) begin
          ok = 1'b1;
          d.mem_size = f3[1:0];
          d.control_bits[CB_SIGN] = ~f3[2];
        end
      end
      OP_STORE: begin
        d.imm_low    = {f7, rd};
        d.read_reg_a = rs2;
        d.read_reg_b = rs1;
        d.alu_code   = ALU_STORE;
        d.control_bits[CB_SRC]  = 1'b1;
        d.control_bits[CB_DSEL] = 1'b1;
        d.control_bits[CB_SIGN] = 1'b1;
        d.control_bits[CB_MWR]  = 1'b1;
        if (f3 <= F3_ST_MAX) begin
          ok = 1'b1;
          d.mem_size = f3[1:0];
        end
      end
      OP_BRANCH: begin
        d.read_reg_a    = rs2;
        d.read_reg_b    = rs1;
        d.branch_offset = {instruction[31], instruction[7], instruction[30:25],
                           instruction[11:8], 1'b0};
        case (f3)
          F3_BEQ: begin
            ok = 1'b1;
            d.alu_code = ALU_BEQ;
            d.branch_condition = BC_EQ;
          end
          F3_BNE: begin
            ok = 1'b1;
            d.alu_code = ALU_BNE;
            d.branch_condition = BC_NE;
          end
          F3_BLT: begin
            ok = 1'b1;
            d.alu_code = ALU_BLT;
            d.branch_condition = BC_LT;
          end
          F3_BGE: begin
            ok = 1'b1;
            d.alu_code = ALU_BGE;
            d.branch_condition = BC_GE;
          end
          F3_BLTU: begin
            ok = 1'b1;
            d.alu_code = ALU_BLTU;
            d.branch_condition = BC_LTU;
          end
          F3_BGEU: begin
            ok = 1'b1;
            d.alu_code = ALU_BGEU;
            d.branch_condition = BC_GEU;
          end
          default: ok = 1'b0;
        endcase
      end
      OP_LUI, OP_AUIPC: begin
        ok = 1'b1;
        d.imm_upper    = instruction[31:12];
        d.write_reg    = rd;
        d.write_select = WSEL_UIMM;
        d.control_bits[CB_WE]   = 1'b1;
        d.control_bits[CB_SIGN] = 1'b1;
        d.control_bits[CB_AUI]  = (op == OP_AUIPC);
      end
      OP_JAL: begin
        ok = 1'b1;
        d.write_reg    = rd;
        d.write_select = WSEL_LINK;
        d.imm_upper    = {instruction[31], instruction[19:12], instruction[20],
                          instruction[30:21]};
        d.control_bits[CB_WE]   = 1'b1;
        d.control_bits[CB_SIGN] = 1'b1;
        d.control_bits[CB_JUMP] = 1'b1;
      end
      OP_JALR: begin
        // funct3 not checked
        ok = 1'b1;
        d.imm_low      = instruction[31:20];
        d.read_reg_a   = rs1;
        d.write_reg    = rd;
        d.write_select = WSEL_LINK;
        d.control_bits[CB_WE]   = 1'b1;
        d.control_bits[CB_SIGN] = 1'b1;
        d.control_bits[CB_JUMP] = 1'b1;
        d.control_bits[CB_JALR] = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    d.valid_res = ok;
    if (!ok) begin
      d = '0;
    end
  end

  assign dec = d;

endmodule
